// ===== sv/stack_calculator_defines.svh =====
// ----------------------------------------------------------------------------
// Stack calculator assertion macros
// Shared property wrappers for the checker, clocked on clk, reset by rst_n.
// ----------------------------------------------------------------------------
`ifndef STACK_CALCULATOR_DEFINES_SVH
`define STACK_CALCULATOR_DEFINES_SVH

// Same-cycle implication
`define SC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stack calculator check failed");

// Next-cycle implication
`define SC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stack calculator check failed");

`endif

// ===== sv/sc_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack calculator package
// Sizes, opcodes, status codes and the ALU request/response structs.
// ----------------------------------------------------------------------------
package sc_pkg;

  // Stack geometry and field widths
  localparam int DEPTH   = 1024;
  localparam int WORD_W  = 32;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int OP_W    = 3;
  localparam int ST_W    = 3;
  localparam int IDX_W   = 10;
  localparam int ENTRY_W = 11;

  typedef logic [OP_W-1:0]    opcode_t;
  typedef logic [ST_W-1:0]    status_t;
  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [CNT_W-1:0]   count_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  // Opcodes
  localparam opcode_t OP_PUSH     = 3'd0;
  localparam opcode_t OP_POP      = 3'd1;
  localparam opcode_t OP_PEEK_TOP = 3'd2;
  localparam opcode_t OP_PEEK_BOT = 3'd3;
  localparam opcode_t OP_ADD      = 3'd4;
  localparam opcode_t OP_SUB      = 3'd5;
  localparam opcode_t OP_MUL      = 3'd6;
  localparam opcode_t OP_DIV      = 3'd7;

  // Status codes
  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_FULL    = 3'd1;
  localparam status_t ST_EMPTY   = 3'd2;
  localparam status_t ST_RANGE   = 3'd3;
  localparam status_t ST_FEW     = 3'd4;
  localparam status_t ST_DIVZERO = 3'd5;

  // Sequencer to ALU
  typedef struct packed {
    logic    start;
    opcode_t op;
    word_t   a;
    word_t   b;
  } alu_req_t;

  // ALU to sequencer
  typedef struct packed {
    logic  done;
    word_t result;
  } alu_rsp_t;

endpackage

// ===== sv/sc_in_if.sv =====
// ----------------------------------------------------------------------------
// Stack calculator command channel
// Valid/ready channel carrying one opcode beat with its operands.
// ----------------------------------------------------------------------------
interface sc_in_if;
  import sc_pkg::*;

  logic                      valid;
  logic                      ready;
  opcode_t                   opcode;
  logic signed [WORD_W-1:0]  operand_value;
  logic [IDX_W-1:0]          offset_index;

  modport source (output valid, opcode, operand_value, offset_index, input ready);
  modport sink   (input valid, opcode, operand_value, offset_index, output ready);
endinterface

// ===== sv/sc_out_if.sv =====
// ----------------------------------------------------------------------------
// Stack calculator result channel
// Valid/ready channel carrying one result beat per command.
// ----------------------------------------------------------------------------
interface sc_out_if;
  import sc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [WORD_W-1:0]  result_value;
  status_t                   status;
  logic [ENTRY_W-1:0]        entry_count;

  modport source (output valid, result_value, status, entry_count, input ready);
  modport sink   (input valid, result_value, status, entry_count, output ready);
endinterface

// ===== sv/stack_calculator.sv =====
// ----------------------------------------------------------------------------
// Stack calculator
// LIFO stack of signed words in a RAM with a stack-machine ALU: push, pop,
// peek from top or bottom, add, subtract, multiply and floor divide.
//
//   channel   dir   beat contents
//   in_if     in    opcode, operand_value, offset_index
//   out_if    out   result_value, status, entry_count
//
// Push and the full, empty, range and operand-count errors go from the accept
// straight to the result register; pop and peek wait for one RAM read and
// divide by zero for two. Add and subtract make one pass of the ALU's shared
// adder; multiply and divide loop on it bit by bit, then divide's sign fix.
// One command at a time: in_if.ready is high only while the sequencer idles.
// A finished result waits in the output register; a stalled out_if holds it.
// Reset clears the entry count; the RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module stack_calculator (
  input  logic            clk,
  input  logic            rst_n,
  sc_in_if.sink           in_if,
  sc_out_if.source        out_if
);
  import sc_pkg::*;

  localparam logic [2:0] T_IDLE = 3'd0;
  localparam logic [2:0] T_RD1  = 3'd1;
  localparam logic [2:0] T_RD2  = 3'd2;
  localparam logic [2:0] T_ALU  = 3'd3;
  localparam logic [2:0] T_RESP = 3'd4;

  logic [2:0] state_r, state_nxt;
  count_t     count_r, count_nxt;
  opcode_t    op_r, op_nxt;
  word_t      top_r, top_nxt;
  word_t      res_r, res_nxt;
  status_t    st_r, st_nxt;
  logic       out_valid_r, out_valid_nxt;
  word_t      out_res_r, out_res_nxt;
  status_t    out_st_r, out_st_nxt;
  count_t     out_cnt_r, out_cnt_nxt;

  logic       accept;
  count_t     cnt_m1, cnt_m2, peek_top, idx_ext;
  logic       idx_oor;

  logic       ram_we, ram_re;
  addr_t      ram_waddr, ram_raddr;
  word_t      ram_wdata, ram_rdata;

  alu_req_t   alu_req;
  alu_rsp_t   alu_rsp;

  sc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sc_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  assign in_if.ready = (state_r == T_IDLE);
  assign accept      = in_if.valid && in_if.ready;

  assign cnt_m1   = count_r - count_t'(1);
  assign cnt_m2   = count_r - count_t'(2);
  assign idx_ext  = count_t'(in_if.offset_index);
  assign peek_top = cnt_m1 - idx_ext;
  assign idx_oor  = (idx_ext >= count_r);

  // Command sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    op_nxt        = op_r;
    top_nxt       = top_r;
    res_nxt       = res_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    out_st_nxt    = out_st_r;
    out_cnt_nxt   = out_cnt_r;
    ram_we        = 1'b0;
    ram_waddr     = count_r[ADDR_W-1:0];
    ram_wdata     = in_if.operand_value;
    ram_re        = 1'b0;
    ram_raddr     = cnt_m1[ADDR_W-1:0];
    alu_req       = '0;

    // Drop the result beat once taken
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      T_IDLE: begin
        if (accept) begin
          op_nxt    = in_if.opcode;
          res_nxt   = '0;
          st_nxt    = ST_OK;
          state_nxt = T_RESP;
          case (in_if.opcode)
            OP_PUSH: begin
              if (count_r == count_t'(DEPTH)) begin
                st_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + count_t'(1);
              end
            end
            OP_POP: begin
              if (count_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                count_nxt = cnt_m1;
                state_nxt = T_RD1;
              end
            end
            OP_PEEK_TOP: begin
              if (idx_oor) begin
                st_nxt = ST_RANGE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = peek_top[ADDR_W-1:0];
                state_nxt = T_RD1;
              end
            end
            OP_PEEK_BOT: begin
              if (idx_oor) begin
                st_nxt = ST_RANGE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = idx_ext[ADDR_W-1:0];
                state_nxt = T_RD1;
              end
            end
            default: begin
              if (count_r < count_t'(2)) begin
                st_nxt = ST_FEW;
              end else begin
                ram_re    = 1'b1;
                state_nxt = T_RD1;
              end
            end
          endcase
        end
      end

      // First read back: the word itself, or the top operand
      T_RD1: begin
        if (op_r inside {OP_POP, OP_PEEK_TOP, OP_PEEK_BOT}) begin
          res_nxt   = ram_rdata;
          state_nxt = T_RESP;
        end else begin
          top_nxt   = ram_rdata;
          ram_re    = 1'b1;
          ram_raddr = cnt_m2[ADDR_W-1:0];
          state_nxt = T_RD2;
        end
      end

      // Next operand in hand: check the divisor, start the ALU
      T_RD2: begin
        if (op_r == OP_DIV && top_r == '0) begin
          st_nxt    = ST_DIVZERO;
          state_nxt = T_RESP;
        end else begin
          alu_req.start = 1'b1;
          alu_req.op    = op_r;
          alu_req.a     = ram_rdata;
          alu_req.b     = top_r;
          state_nxt     = T_ALU;
        end
      end

      // Replace the top two entries with the ALU result
      T_ALU: begin
        if (alu_rsp.done) begin
          res_nxt   = alu_rsp.result;
          ram_we    = 1'b1;
          ram_waddr = cnt_m2[ADDR_W-1:0];
          ram_wdata = alu_rsp.result;
          count_nxt = cnt_m1;
          state_nxt = T_RESP;
        end
      end

      // Load the output register when it is free
      T_RESP: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_st_nxt    = st_r;
          out_cnt_nxt   = count_r;
          state_nxt     = T_IDLE;
        end
      end

      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r      <= op_nxt;
    top_r     <= top_nxt;
    res_r     <= res_nxt;
    st_r      <= st_nxt;
    out_res_r <= out_res_nxt;
    out_st_r  <= out_st_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.result_value = out_res_r;
  assign out_if.status       = out_st_r;
  assign out_if.entry_count  = ENTRY_W'(out_cnt_r);
endmodule

// ===== sv/sc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write, then registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ===== sv/sc_alu.sv =====
// ----------------------------------------------------------------------------
// Stack calculator ALU
// One shared adder/subtractor stepped by a small sequencer: add and subtract
// in one pass, shift-add multiply and restoring floor divide one bit a step.
// ----------------------------------------------------------------------------
module sc_alu (
  input  logic             clk,
  input  logic             rst_n,
  input  sc_pkg::alu_req_t req,
  output sc_pkg::alu_rsp_t rsp
);
  import sc_pkg::*;

  localparam int ADD_W  = WORD_W + 2;
  localparam int STEP_W = $clog2(WORD_W);

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_ADD  = 3'd1;
  localparam logic [2:0] A_MUL  = 3'd2;
  localparam logic [2:0] A_DIV  = 3'd3;
  localparam logic [2:0] A_FIX  = 3'd4;
  localparam logic [2:0] A_DONE = 3'd5;

  logic [2:0]        state_r, state_nxt;
  opcode_t           op_r, op_nxt;
  word_t             acc_r, acc_nxt;
  word_t             opa_r, opa_nxt;
  word_t             opb_r, opb_nxt;
  logic              neg_r, neg_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;

  logic [ADD_W-1:0]  add_a, add_b, add_sum;
  logic              add_inv, add_cin;
  logic              last_step;
  word_t             abs_a, abs_b;

  // Shared adder
  assign add_sum = add_a + (add_inv ? ~add_b : add_b) + ADD_W'(add_cin);

  assign last_step = (cnt_r == STEP_W'(WORD_W - 1));
  assign abs_a     = req.a[WORD_W-1] ? (~req.a + word_t'(1)) : req.a;
  assign abs_b     = req.b[WORD_W-1] ? (~req.b + word_t'(1)) : req.b;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    acc_nxt   = acc_r;
    opa_nxt   = opa_r;
    opb_nxt   = opb_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    add_a     = '0;
    add_b     = '0;
    add_inv   = 1'b0;
    add_cin   = 1'b0;

    case (state_r)
      A_IDLE: begin
        if (req.start) begin
          op_nxt  = req.op;
          cnt_nxt = '0;
          acc_nxt = '0;
          opa_nxt = req.a;
          opb_nxt = req.b;
          case (req.op)
            OP_MUL: state_nxt = A_MUL;
            OP_DIV: begin
              opa_nxt   = abs_a;
              opb_nxt   = abs_b;
              neg_nxt   = req.a[WORD_W-1] ^ req.b[WORD_W-1];
              state_nxt = A_DIV;
            end
            default: state_nxt = A_ADD;
          endcase
        end
      end

      // Add or subtract in a single pass
      A_ADD: begin
        add_a     = {2'b00, opa_r};
        add_b     = {2'b00, opb_r};
        add_inv   = (op_r == OP_SUB);
        add_cin   = (op_r == OP_SUB);
        acc_nxt   = add_sum[WORD_W-1:0];
        state_nxt = A_DONE;
      end

      // Accumulate the shifted multiplicand for each set multiplier bit
      A_MUL: begin
        add_a = {2'b00, acc_r};
        add_b = {2'b00, opa_r};
        if (opb_r[0]) begin
          acc_nxt = add_sum[WORD_W-1:0];
        end
        opa_nxt = {opa_r[WORD_W-2:0], 1'b0};
        opb_nxt = {1'b0, opb_r[WORD_W-1:1]};
        cnt_nxt = cnt_r + STEP_W'(1);
        if (last_step) begin
          state_nxt = A_DONE;
        end
      end

      // Restoring divide: trial subtract, keep on no borrow
      A_DIV: begin
        add_a   = {1'b0, acc_r, opa_r[WORD_W-1]};
        add_b   = {2'b00, opb_r};
        add_inv = 1'b1;
        add_cin = 1'b1;
        if (!add_sum[ADD_W-1]) begin
          acc_nxt = add_sum[WORD_W-1:0];
        end else begin
          acc_nxt = {acc_r[WORD_W-2:0], opa_r[WORD_W-1]};
        end
        opa_nxt = {opa_r[WORD_W-2:0], ~add_sum[ADD_W-1]};
        cnt_nxt = cnt_r + STEP_W'(1);
        if (last_step) begin
          state_nxt = A_FIX;
        end
      end

      // Floor on mixed signs: -(q + (rem != 0)) = ~q + (rem == 0)
      A_FIX: begin
        add_a     = {2'b00, ~opa_r};
        add_cin   = (acc_r == '0);
        acc_nxt   = neg_r ? add_sum[WORD_W-1:0] : opa_r;
        state_nxt = A_DONE;
      end

      A_DONE: state_nxt = A_IDLE;

      default: state_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    op_r  <= op_nxt;
    acc_r <= acc_nxt;
    opa_r <= opa_nxt;
    opb_r <= opb_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done   = (state_r == A_DONE);
  assign rsp.result = acc_r;
endmodule

// ===== sv/sc_checker.sv =====
// ----------------------------------------------------------------------------
// Stack calculator checker
// Port-level properties of the stack calculator, attached by bind.
// ----------------------------------------------------------------------------
`include "stack_calculator_defines.svh"

module sc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [sc_pkg::WORD_W-1:0] out_result_value,
  input sc_pkg::status_t                out_status,
  input logic [sc_pkg::ENTRY_W-1:0]     out_entry_count
);
  import sc_pkg::*;

  // One command in flight: ready drops right after an accepted beat
  `SC_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // Every error beat carries a zero word
  `SC_ASSERT_IMP(a_error_zero, out_valid && out_status != ST_OK, out_result_value == '0)

  // Entry count never exceeds the stack depth
  `SC_ASSERT_IMP(a_count_bound, out_valid, out_entry_count <= ENTRY_W'(DEPTH))

  // A stalled result beat holds
  `SC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_result_value) && $stable(out_status) && $stable(out_entry_count))
endmodule

bind stack_calculator sc_checker u_sc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_if.valid),
  .in_ready         (in_if.ready),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_result_value (out_if.result_value),
  .out_status       (out_if.status),
  .out_entry_count  (out_if.entry_count)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Stack calculator testbench
// Drives command beats into the stack calculator and checks every result beat
// against a scoreboard that keeps its own stack and ALU. A short directed run
// covers the empty, range, operand-count and divide-by-zero errors and the
// arithmetic extremes, then random command streams in three idling patterns.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sc_pkg::*;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  typedef struct packed {
    word_t   value;
    status_t status;
    entry_t  entries;
  } calc_result_t;

  localparam word_t WORD_MIN  = 32'h8000_0000;
  localparam word_t WORD_MAX  = 32'h7fff_ffff;
  localparam word_t WORD_ONES = 32'hffff_ffff;

  // Stack and ALU shadow; one expected result per accepted command
  class stack_scoreboard;
    word_t          stack_words [DEPTH];
    int unsigned    entries;
    calc_result_t   pending [$];
    int unsigned    mismatches;

    function new();
      entries    = 0;
      mismatches = 0;
    endfunction

    task report(input string msg);
      $display("%0t ns: mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    // Floor of num / den on signed words; the most negative by -1 wraps
    function automatic word_t floor_quotient(input word_t num, input word_t den);
      longint n;
      longint d;
      longint q;
      longint r;
      n = longint'($signed(num));
      d = longint'($signed(den));
      q = n / d;
      r = n % d;
      if (r != 0 && ((n < 0) != (d < 0))) q = q - 1;
      return q[WORD_W-1:0];
    endfunction

    function void note_command(input opcode_t op, input word_t val, input idx_t idx);
      calc_result_t exp_res;
      word_t        top;
      word_t        nxt;
      word_t        res;
      exp_res.value  = '0;
      exp_res.status = ST_OK;
      case (op)
        OP_PUSH: begin
          if (entries >= DEPTH) exp_res.status = ST_FULL;
          else begin
            stack_words[entries] = val;
            entries++;
          end
        end
        OP_POP: begin
          if (entries == 0) exp_res.status = ST_EMPTY;
          else begin
            entries--;
            exp_res.value = stack_words[entries];
          end
        end
        OP_PEEK_TOP, OP_PEEK_BOT: begin
          if (idx >= entries) exp_res.status = ST_RANGE;
          else if (op == OP_PEEK_TOP) exp_res.value = stack_words[entries - 1 - idx];
          else exp_res.value = stack_words[idx];
        end
        default: begin
          if (entries < 2) exp_res.status = ST_FEW;
          else begin
            top = stack_words[entries - 1];
            nxt = stack_words[entries - 2];
            if (op == OP_DIV && top == '0) exp_res.status = ST_DIVZERO;
            else begin
              case (op)
                OP_ADD:  res = nxt + top;
                OP_SUB:  res = nxt - top;
                OP_MUL:  res = nxt * top;
                default: res = floor_quotient(nxt, top);
              endcase
              entries--;
              stack_words[entries - 1] = res;
              exp_res.value = res;
            end
          end
        end
      endcase
      exp_res.entries = entry_t'(entries);
      pending.push_back(exp_res);
    endfunction

    task check_result(input word_t value, input status_t st, input entry_t cnt);
      calc_result_t exp_res;
      if (pending.size() == 0) begin
        report($sformatf("result beat with no command waiting (value %h status %0d)",
                         value, st));
      end else begin
        exp_res = pending.pop_front();
        if (value !== exp_res.value)
          report($sformatf("result_value %h, expected %h", value, exp_res.value));
        if (st !== exp_res.status)
          report($sformatf("status %0d, expected %0d", st, exp_res.status));
        if (cnt !== exp_res.entries)
          report($sformatf("entry_count %0d, expected %0d", cnt, exp_res.entries));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;

  stack_scoreboard sb = new();

  sc_in_if  cmd_ch ();
  sc_out_if res_ch ();

  stack_calculator i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (cmd_ch),
    .out_if (res_ch)
  );

  // Clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Give up after a generous fixed time
  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: stall at random, change ready on the falling edge
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every result beat taken at the rising edge
  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready)
      sb.check_result(res_ch.result_value, res_ch.status, res_ch.entry_count);
  end

  // Send one command beat; entered and left at a falling edge
  task send_command(input opcode_t op, input word_t val, input idx_t idx);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid         <= 1'b1;
    cmd_ch.opcode        <= op;
    cmd_ch.operand_value <= val;
    cmd_ch.offset_index  <= idx;
    do @(posedge clk); while (!cmd_ch.ready);
    sb.note_command(op, val, idx);
    @(negedge clk);
  endtask

  task push_word(input word_t val);
    send_command(OP_PUSH, val, idx_t'($urandom));
  endtask

  task alu_op(input opcode_t op);
    send_command(op, word_t'($urandom), idx_t'($urandom));
  endtask

  // Operand mix: extremes, zeros for divide by zero, small and full-range words
  function automatic word_t pick_word();
    int unsigned sel;
    sel = $urandom_range(9);
    case (sel)
      0:       return '0;
      1:       return 32'd1;
      2:       return WORD_ONES;
      3:       return WORD_MIN;
      4:       return WORD_MAX;
      5, 6:    return word_t'($signed($urandom_range(20)) - 10);
      default: return word_t'($urandom);
    endcase
  endfunction

  // Error cases first, then arithmetic corners
  task run_directed();
    send_command(OP_POP, word_t'($urandom), '0);
    send_command(OP_PEEK_TOP, '0, '0);
    send_command(OP_PEEK_BOT, WORD_ONES, '1);
    alu_op(OP_ADD);
    push_word(32'd7);
    alu_op(OP_DIV);
    send_command(OP_PEEK_TOP, '0, '0);
    send_command(OP_PEEK_TOP, '0, idx_t'(1));
    push_word('0);
    alu_op(OP_DIV);
    send_command(OP_POP, '0, '0);
    push_word(WORD_MIN);
    push_word(WORD_ONES);
    alu_op(OP_DIV);
    push_word(WORD_MAX);
    alu_op(OP_ADD);
    alu_op(OP_SUB);
    push_word(word_t'(-3));
    alu_op(OP_DIV);
    push_word(WORD_MAX);
    alu_op(OP_MUL);
    push_word(word_t'(-7));
    push_word(32'd2);
    alu_op(OP_DIV);
    send_command(OP_PEEK_BOT, '0, '0);
  endtask

  // Random command stream; keep the stack shallow so arithmetic stays common
  task run_random(input int n);
    int unsigned r;
    int unsigned depth_now;
    opcode_t     op;
    idx_t        idx;
    for (int i = 0; i < n; i++) begin
      depth_now = sb.entries;
      r = $urandom_range(99);
      if (r < 32 || (depth_now < 2 && r < 60)) op = OP_PUSH;
      else if (r < 42) op = OP_POP;
      else if (r < 52) op = OP_PEEK_TOP;
      else if (r < 62) op = OP_PEEK_BOT;
      else op = opcode_t'(OP_ADD + $urandom_range(3));
      if (op == OP_PUSH && depth_now >= 40 && $urandom_range(1) == 1) op = OP_POP;
      if (depth_now > 0 && $urandom_range(99) < 75)
        idx = idx_t'($urandom_range(depth_now - 1));
      else
        idx = idx_t'($urandom);
      send_command(op, (op == OP_PUSH) ? pick_word() : word_t'($urandom), idx);
    end
  endtask

  // Main sequence
  initial begin
    send_idle_pct        = 0;
    recv_idle_pct        = 0;
    rst_n                = 1'b0;
    cmd_ch.valid         = 1'b0;
    cmd_ch.opcode        = OP_PUSH;
    cmd_ch.operand_value = '0;
    cmd_ch.offset_index  = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 26;
    recv_idle_pct = 57;
    run_directed();
    run_random(300);

    send_idle_pct = 57;
    recv_idle_pct = 26;
    run_random(300);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(320);
    cmd_ch.valid <= 1'b0;

    // Drain outstanding results, then watch for stray beats
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending.size()));

    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
